>>> rtl/core/lookahead_path_intersection_top_defines.svh
// assertion macros for the lookahead path intersection block
`ifndef LOOKAHEAD_PATH_INTERSECTION_TOP_DEFINES_SVH
`define LOOKAHEAD_PATH_INTERSECTION_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LAPI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LAPI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lapi_pkg.sv
// types and constants of the lookahead path intersection block
`timescale 1ns / 1ps

package lapi_pkg;

   localparam int MAX_POINTS   = 256;
   localparam int PTR_WIDTH    = 8;
   localparam int COUNT_WIDTH  = 9;
   localparam int COORD_WIDTH  = 32;
   localparam int RADIUS_WIDTH = 31;
   localparam int PADDR_WIDTH  = 3;
   localparam int SQRT_STEPS   = 64;
   localparam int DIV_STEPS    = 128;

   // smallest squared segment length that is scanned, raw units
   localparam logic [62:0] MIN_SEG_LEN2 = 63'd5;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 31'd786432;

   // register index
   localparam logic [0:0] REG_LOOKAHEAD_RADIUS = 1'b0;

   // commands
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [COORD_WIDTH-1:0] waypoint_x;
      logic signed [COORD_WIDTH-1:0] waypoint_y;
      logic signed [COORD_WIDTH-1:0] pose_x;
      logic signed [COORD_WIDTH-1:0] pose_y;
      logic [PTR_WIDTH-1:0]          start_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
      logic [PTR_WIDTH-1:0]          segment_index;
      logic                          on_segment;
      logic [1:0]                    status;
   } rsp_type;

endpackage

>>> rtl/core/lookahead_path_intersection_top.sv
// lookahead point search over a stored waypoint path
//
//   port group   direction   handshake                 payload
//   req_         in          req_valid / req_ready     lapi_pkg::req_type
//   rsp_         out         rsp_valid / rsp_ready     lapi_pkg::rsp_type
//   apb          in          psel / penable / pready   lookahead radius register
//
// a query scans the stored segments in turn; each one is skipped early or qualifies,
// and the scan uses one 32x32 multiplier run four times per product, a 64-step
// square root and two 128-step divisions on one shared datapath.
// reset clears the point count and control; the path store is not cleared.
// req_ready is high only while idle; a result waits in its output register
// while the next item is taken.
`timescale 1ns / 1ps
`include "lookahead_path_intersection_top_defines.svh"

module lookahead_path_intersection_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lapi_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lapi_pkg::rsp_type                     rsp_payload,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lapi_pkg::PADDR_WIDTH-1:0]      paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_POST  = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_NEXT  = 4'd7;
   localparam logic [3:0] S_FINAL = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   // product steps of one segment
   localparam logic [3:0] STEP_AXX  = 4'd0;
   localparam logic [3:0] STEP_AYY  = 4'd1;
   localparam logic [3:0] STEP_BXF  = 4'd2;
   localparam logic [3:0] STEP_BYF  = 4'd3;
   localparam logic [3:0] STEP_FXX  = 4'd4;
   localparam logic [3:0] STEP_FYY  = 4'd5;
   localparam logic [3:0] STEP_RR   = 4'd6;
   localparam logic [3:0] STEP_BB   = 4'd7;
   localparam logic [3:0] STEP_AC   = 4'd8;
   localparam logic [3:0] STEP_EX   = 4'd9;
   localparam logic [3:0] STEP_EY   = 4'd10;
   localparam logic [3:0] STEP_OFFX = 4'd11;
   localparam logic [3:0] STEP_OFFY = 4'd12;

   localparam logic [2:0] MUL_LAST = 3'd4;

   // saturate a 33-bit difference to the symmetric 32-bit range
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -33'sd2147483647) begin
         r = 32'sh80000001;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  ph_ff, ph_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [lapi_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [lapi_pkg::RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic [lapi_pkg::PTR_WIDTH-1:0] idx_ff, idx_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        found_ff, found_in;
   logic [lapi_pkg::PTR_WIDTH-1:0] best_ff, best_in;
   logic [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [62:0] a_ff, a_in;
   logic signed [63:0] b_ff, b_in;
   logic [62:0] ff_ff, ff_in;
   logic [61:0] r2_ff, r2_in;
   logic [62:0] cm_ff, cm_in;
   logic        cpos_ff, cpos_in;
   logic [127:0] disc_ff, disc_in;
   logic [64:0] e2_ff, e2_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] pp_ff, pp_in;
   logic [1:0]  sh_ff, sh_in;
   logic [63:0] root_ff, root_in;
   logic [66:0] rem_ff, rem_in;
   logic [62:0] drem_ff, drem_in;
   logic [31:0] q_ff, q_in, qx_ff, qx_in;
   lapi_pkg::rsp_type res_ff, res_in;
   lapi_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // path store
   logic [31:0] mem_x [lapi_pkg::MAX_POINTS];
   logic [31:0] mem_y [lapi_pkg::MAX_POINTS];
   logic [31:0] rx0_ff, rx1_ff, ry0_ff, ry1_ff;
   logic [lapi_pkg::PTR_WIDTH-1:0] addr0, addr1, last_idx;
   logic        cont;
   logic        req_xfer, mem_wr;

   // derived operands
   logic [30:0] dxm, dym, fxm, fym;
   logic signed [32:0] ex_s, ey_s;
   logic [31:0] exm, eym;
   logic [62:0] bm;
   logic [63:0] n_c;
   logic [63:0] op_a, op_b;
   logic [31:0] a_part, b_part;
   logic [127:0] pp_wide;

   // sqrt and divide step values
   logic [66:0] rem_sh, trial;
   logic [63:0] dtmp;

   // post-step values
   logic [62:0] a_sum;
   logic [64:0] e2_sum;
   logic        cpos_c;
   logic        skip_geom;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2:2] == lapi_pkg::REG_LOOKAHEAD_RADIUS) ? {1'b0, radius_ff} : 32'd0;

   // read addresses: segment endpoints, or the final point once the scan ends
   assign last_idx = lapi_pkg::PTR_WIDTH'(count_ff - 9'd1);
   assign cont     = ({1'b0, idx_ff} + 9'd1) < count_ff;
   assign addr0    = cont ? idx_ff : last_idx;
   assign addr1    = idx_ff + 8'd1;
   assign mem_wr   = req_xfer && (req_payload.command == lapi_pkg::CMD_APPEND) &&
                     (count_ff < 9'(lapi_pkg::MAX_POINTS));

   // store write and registered reads
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_x[count_ff[lapi_pkg::PTR_WIDTH-1:0]] <= req_payload.waypoint_x;
         mem_y[count_ff[lapi_pkg::PTR_WIDTH-1:0]] <= req_payload.waypoint_y;
      end
      rx0_ff <= mem_x[addr0];
      rx1_ff <= mem_x[addr1];
      ry0_ff <= mem_y[addr0];
      ry1_ff <= mem_y[addr1];
   end

   // magnitudes and signs
   assign dxm  = dx_ff[31] ? 31'(-dx_ff) : dx_ff[30:0];
   assign dym  = dy_ff[31] ? 31'(-dy_ff) : dy_ff[30:0];
   assign fxm  = fx_ff[31] ? 31'(-fx_ff) : fx_ff[30:0];
   assign fym  = fy_ff[31] ? 31'(-fy_ff) : fy_ff[30:0];
   assign ex_s = {fx_ff[31], fx_ff} + {dx_ff[31], dx_ff};
   assign ey_s = {fy_ff[31], fy_ff} + {dy_ff[31], dy_ff};
   assign exm  = ex_s[32] ? 32'(-ex_s) : ex_s[31:0];
   assign eym  = ey_s[32] ? 32'(-ey_s) : ey_s[31:0];
   assign bm   = b_ff[63] ? 63'(-b_ff) : b_ff[62:0];
   assign n_c  = b_ff[63] ? (root_ff + {1'b0, bm}) : (root_ff - {1'b0, bm});

   // multiplier operand select
   always_comb begin
      op_a = 64'd0;
      op_b = 64'd0;
      unique case (step_ff)
         STEP_AXX:  begin op_a = {33'd0, dxm}; op_b = {33'd0, dxm}; end
         STEP_AYY:  begin op_a = {33'd0, dym}; op_b = {33'd0, dym}; end
         STEP_BXF:  begin op_a = {33'd0, dxm}; op_b = {33'd0, fxm}; end
         STEP_BYF:  begin op_a = {33'd0, dym}; op_b = {33'd0, fym}; end
         STEP_FXX:  begin op_a = {33'd0, fxm}; op_b = {33'd0, fxm}; end
         STEP_FYY:  begin op_a = {33'd0, fym}; op_b = {33'd0, fym}; end
         STEP_RR:   begin op_a = {33'd0, radius_ff}; op_b = {33'd0, radius_ff}; end
         STEP_BB:   begin op_a = {1'b0, bm}; op_b = {1'b0, bm}; end
         STEP_AC:   begin op_a = {1'b0, a_ff}; op_b = {1'b0, cm_ff}; end
         STEP_EX:   begin op_a = {32'd0, exm}; op_b = {32'd0, exm}; end
         STEP_EY:   begin op_a = {32'd0, eym}; op_b = {32'd0, eym}; end
         STEP_OFFX: begin op_a = {33'd0, dxm}; op_b = n_c; end
         STEP_OFFY: begin op_a = {33'd0, dym}; op_b = n_c; end
         default:   begin op_a = 64'd0; op_b = 64'd0; end
      endcase
   end

   // partial product halves and their shift
   assign a_part = ph_ff[1] ? op_a[63:32] : op_a[31:0];
   assign b_part = ph_ff[0] ? op_b[63:32] : op_b[31:0];

   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_wide = {64'd0, pp_ff};
         2'd1:    pp_wide = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_wide = {pp_ff, 64'd0};
         default: pp_wide = 128'd0;
      endcase
   end

   // square root and divide step
   assign rem_sh = {rem_ff[64:0], disc_ff[127:126]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign dtmp   = {drem_ff, disc_ff[127]};

   // post-step helpers
   assign a_sum     = a_ff + acc_ff[62:0];
   assign e2_sum    = e2_ff + {1'b0, acc_ff[63:0]};
   assign cpos_c    = ff_ff > {1'b0, acc_ff[61:0]};
   assign skip_geom = (!b_ff[63] && (b_ff != 64'sd0) && cpos_c) || (b_ff[63] && (a_ff < bm));

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      found_in = found_ff;
      best_in  = best_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      ff_in    = ff_ff;
      r2_in    = r2_ff;
      cm_in    = cm_ff;
      cpos_in  = cpos_ff;
      disc_in  = disc_ff;
      e2_in    = e2_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      drem_in  = drem_ff;
      q_in     = q_ff;
      qx_in    = qx_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_payload.command)
                  lapi_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  lapi_pkg::CMD_APPEND: begin
                     if (mem_wr) begin
                        count_in = count_ff + 9'd1;
                     end else begin
                        res_in.status = lapi_pkg::STATUS_FULL;
                     end
                  end
                  lapi_pkg::CMD_QUERY: begin
                     if (count_ff == '0) begin
                        res_in.status = lapi_pkg::STATUS_EMPTY;
                     end else begin
                        cx_in    = req_payload.pose_x;
                        cy_in    = req_payload.pose_y;
                        found_in = 1'b0;
                        idx_in   = ({1'b0, req_payload.start_index} >= count_ff) ?
                                   last_idx : req_payload.start_index;
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            state_in = cont ? S_DIFF : S_FINAL;
         end
         S_DIFF: begin
            dx_in    = sat33({rx1_ff[31], rx1_ff} - {rx0_ff[31], rx0_ff});
            dy_in    = sat33({ry1_ff[31], ry1_ff} - {ry0_ff[31], ry0_ff});
            fx_in    = sat33({rx0_ff[31], rx0_ff} - {cx_ff[31], cx_ff});
            fy_in    = sat33({ry0_ff[31], ry0_ff} - {cy_ff[31], cy_ff});
            step_in  = STEP_AXX;
            ph_in    = '0;
            state_in = S_MUL;
         end
         // four partial products, each registered and added to the sum in the next cycle
         S_MUL: begin
            if (ph_ff != MUL_LAST) begin
               pp_in = a_part * b_part;
               sh_in = {1'b0, ph_ff[1]} + {1'b0, ph_ff[0]};
            end
            if (ph_ff != 3'd0) begin
               acc_in = ((ph_ff == 3'd1) ? 128'd0 : acc_ff) + pp_wide;
            end
            ph_in = ph_ff + 3'd1;
            if (ph_ff == MUL_LAST) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            ph_in    = '0;
            step_in  = step_ff + 4'd1;
            state_in = S_MUL;
            unique case (step_ff)
               STEP_AXX: a_in = acc_ff[62:0];
               STEP_AYY: begin
                  a_in = a_sum;
                  if (a_sum < lapi_pkg::MIN_SEG_LEN2) begin
                     state_in = S_NEXT;
                  end
               end
               STEP_BXF: b_in = (dx_ff[31] ^ fx_ff[31]) ? (64'sd0 - $signed(acc_ff[63:0])) :
                                                           $signed(acc_ff[63:0]);
               STEP_BYF: b_in = (dy_ff[31] ^ fy_ff[31]) ? (b_ff - $signed(acc_ff[63:0])) :
                                                           (b_ff + $signed(acc_ff[63:0]));
               STEP_FXX: ff_in = acc_ff[62:0];
               STEP_FYY: ff_in = ff_ff + acc_ff[62:0];
               STEP_RR: begin
                  r2_in   = acc_ff[61:0];
                  cpos_in = cpos_c;
                  cm_in   = cpos_c ? (ff_ff - {1'b0, acc_ff[61:0]}) :
                                     ({1'b0, acc_ff[61:0]} - ff_ff);
                  if (skip_geom) begin
                     state_in = S_NEXT;
                  end
               end
               STEP_BB: disc_in = acc_ff;
               STEP_AC: begin
                  if (cpos_ff) begin
                     if (disc_ff < acc_ff) begin
                        state_in = S_NEXT;
                     end else begin
                        disc_in = disc_ff - acc_ff;
                     end
                  end else begin
                     disc_in = disc_ff + acc_ff;
                  end
               end
               STEP_EX: e2_in = {1'b0, acc_ff[63:0]};
               STEP_EY: begin
                  if (e2_sum < {3'd0, r2_ff}) begin
                     state_in = S_NEXT;
                  end else begin
                     root_in  = '0;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_SQRT;
                  end
               end
               STEP_OFFX, STEP_OFFY: begin
                  disc_in  = acc_ff + {66'd0, a_ff[62:1]};
                  drem_in  = '0;
                  cnt_in   = '0;
                  step_in  = step_ff;
                  state_in = S_DIV;
               end
               default: state_in = S_NEXT;
            endcase
         end
         // one root bit per cycle, two radicand bits consumed
         S_SQRT: begin
            disc_in = {disc_ff[125:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[62:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(lapi_pkg::SQRT_STEPS - 1)) begin
               step_in  = STEP_OFFX;
               ph_in    = '0;
               state_in = S_MUL;
            end
         end
         // restoring division, one quotient bit per cycle
         S_DIV: begin
            disc_in = {disc_ff[126:0], 1'b0};
            if (dtmp >= {1'b0, a_ff}) begin
               drem_in = 63'(dtmp - {1'b0, a_ff});
               q_in    = {q_ff[30:0], 1'b1};
            end else begin
               drem_in = dtmp[62:0];
               q_in    = {q_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(lapi_pkg::DIV_STEPS - 1)) begin
               if (step_ff == STEP_OFFX) begin
                  qx_in    = q_in;
                  step_in  = STEP_OFFY;
                  ph_in    = '0;
                  state_in = S_MUL;
               end else begin
                  tx_in    = rx0_ff + (dx_ff[31] ? (32'd0 - qx_ff) : qx_ff);
                  ty_in    = ry0_ff + (dy_ff[31] ? (32'd0 - q_in) : q_in);
                  best_in  = idx_ff;
                  found_in = 1'b1;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            idx_in   = idx_ff + 8'd1;
            state_in = S_CHECK;
         end
         S_FINAL: begin
            res_in = '0;
            if (found_ff) begin
               res_in.target_x      = tx_ff;
               res_in.target_y      = ty_ff;
               res_in.segment_index = best_ff;
               res_in.on_segment    = 1'b1;
            end else begin
               res_in.target_x      = rx0_ff;
               res_in.target_y      = ry0_ff;
               res_in.segment_index = last_idx;
               res_in.on_segment    = 1'b0;
            end
            res_in.status = lapi_pkg::STATUS_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // radius register write
   always_comb begin
      radius_in = radius_ff;
      if (psel && penable && pwrite && pready &&
          (paddr[2:2] == lapi_pkg::REG_LOOKAHEAD_RADIUS)) begin
         radius_in = pwdata[lapi_pkg::RADIUS_WIDTH-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         radius_ff    <= lapi_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      ph_ff   <= ph_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      best_ff <= best_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      ff_ff   <= ff_in;
      r2_ff   <= r2_in;
      cm_ff   <= cm_in;
      cpos_ff <= cpos_in;
      disc_ff <= disc_in;
      e2_ff   <= e2_in;
      acc_ff  <= acc_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      drem_ff <= drem_in;
      q_ff    <= q_in;
      qx_ff   <= qx_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // checks
   `LAPI_ASSERT_NXT(a_append_count, clock, reset, mem_wr, count_ff == $past(count_ff) + 9'd1, "append did not grow the path")
   `LAPI_ASSERT_IMP(a_hit_status_ok, clock, reset, rsp_valid_ff && rsp_ff.on_segment, rsp_ff.status == lapi_pkg::STATUS_OK, "hit with nonzero status")
   `LAPI_ASSERT_IMP(a_mul_phase, clock, reset, state_ff == S_MUL, ph_ff <= MUL_LAST, "multiplier phase out of range")

endmodule
